>>> rtl/core/twem_pkg.sv
// Shared types, constants and helper functions for the twist exponential map.
// Depends on nothing; every other file of the block but twem_if imports it.
package twem_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int DATA_WIDTH_DEF   = 32;

    // Number of compare-subtract cells in the angle reduction chain.
    localparam int MOD_CELLS = 15;

    localparam int MOD_W = 51;   // reduction chain width, unsigned
    localparam int CW    = 36;   // CORDIC datapath width, signed

    typedef logic signed [31:0] word_t;
    typedef logic signed [71:0] wide_t;

    localparam logic [MOD_W-1:0]   TWO_PI_Q32     = 51'h6487ED511;
    localparam logic signed [37:0] PI_Q32         = 38'sh3243F6A89;
    localparam logic signed [37:0] HALF_PI_Q32    = 38'sh1921FB544;
    localparam logic signed [37:0] TWO_PI_Q32_S   = 38'sh6487ED511;
    localparam logic signed [CW-1:0] CORDIC_INV_GAIN = 36'sh026DD3B6A;
    localparam word_t Q30_ONE    = 32'sh40000000;
    localparam word_t AXIS_LIMIT = 32'sd65536;

    typedef struct packed {
        word_t v0;
        word_t v1;
        word_t v2;
        word_t w0;
        word_t w1;
        word_t w2;
        word_t th;
        logic  zero;
        logic  flip;
    } side_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cordic_t;

    // Arctangent of 2^-i in Q2.30.
    function automatic word_t atan_entry(input int unsigned i);
        word_t a;
        case (i)
            0:  a = 32'sh3243F6A8;
            1:  a = 32'sh1DAC6705;
            2:  a = 32'sh0FADBAFC;
            3:  a = 32'sh07F56EA6;
            4:  a = 32'sh03FEAB76;
            5:  a = 32'sh01FFD55B;
            6:  a = 32'sh00FFFAAA;
            7:  a = 32'sh007FFF55;
            8:  a = 32'sh003FFFEA;
            9:  a = 32'sh001FFFFD;
            10: a = 32'sh000FFFFF;
            11: a = 32'sh0007FFFF;
            12: a = 32'sh0003FFFF;
            13: a = 32'sh0001FFFF;
            14: a = 32'sh0000FFFF;
            15: a = 32'sh00007FFF;
            16: a = 32'sh00003FFF;
            17: a = 32'sh00001FFF;
            18: a = 32'sh00000FFF;
            19: a = 32'sh000007FF;
            20: a = 32'sh000003FF;
            21: a = 32'sh000001FF;
            22: a = 32'sh000000FF;
            23: a = 32'sh0000007F;
            24: a = 32'sh0000003F;
            25: a = 32'sh0000001F;
            26: a = 32'sh0000000F;
            27: a = 32'sh00000008;
            28: a = 32'sh00000004;
            29: a = 32'sh00000002;
            30: a = 32'sh00000001;
            default: a = 32'sh00000000;
        endcase
        return a;
    endfunction

    // Drop 30 fraction bits, rounding to nearest with halves going up.
    function automatic wide_t rnd30(input wide_t x);
        return (x + (72'sd1 <<< 29)) >>> 30;
    endfunction

endpackage

>>> rtl/core/twem_if.sv
// Request and response channel interfaces of the twist exponential map.
// Depends on nothing; the payload fields are fixed 32-bit signed words.
interface twem_req_if;
    logic valid;
    logic ready;
    logic signed [31:0] lin_x;
    logic signed [31:0] lin_y;
    logic signed [31:0] lin_z;
    logic signed [31:0] ang_x;
    logic signed [31:0] ang_y;
    logic signed [31:0] ang_z;
    logic signed [31:0] theta;
    modport source(output valid, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, theta,
                   input ready);
    modport sink(input valid, lin_x, lin_y, lin_z, ang_x, ang_y, ang_z, theta,
                 output ready);
endinterface

interface twem_rsp_if;
    logic valid;
    logic ready;
    logic signed [31:0] rot_00;
    logic signed [31:0] rot_01;
    logic signed [31:0] rot_02;
    logic signed [31:0] rot_10;
    logic signed [31:0] rot_11;
    logic signed [31:0] rot_12;
    logic signed [31:0] rot_20;
    logic signed [31:0] rot_21;
    logic signed [31:0] rot_22;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
    modport source(output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                   rot_20, rot_21, rot_22, trans_x, trans_y, trans_z, input ready);
    modport sink(input valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                 rot_20, rot_21, rot_22, trans_x, trans_y, trans_z, output ready);
endinterface

>>> rtl/core/twem_mod_cell.sv
// One cell of the angle reduction chain: a conditional subtract of 2*pi << K.
// Depends on twem_pkg.
module twem_mod_cell
    import twem_pkg::*;
#(
    parameter int K = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             valid_in,
    input  logic [MOD_W-1:0] r_in,
    input  side_t            side_in,
    output logic             valid_out,
    output logic [MOD_W-1:0] r_out,
    output side_t            side_out
);

    localparam logic [MOD_W-1:0] SUB = TWO_PI_Q32 << K;

    logic             valid_reg;
    logic [MOD_W-1:0] r_reg;
    logic [MOD_W-1:0] r_next;
    side_t            side_reg;

    always_comb
    begin
        r_next = (r_in >= SUB) ? (r_in - SUB) : r_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg    <= r_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign r_out     = r_reg;
    assign side_out  = side_reg;

endmodule

>>> rtl/core/twem_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation with a fixed shift of I.
// Depends on twem_pkg.
module twem_cordic_cell
    import twem_pkg::*;
#(
    parameter int I = 0
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    adv,
    input  logic    valid_in,
    input  cordic_t d_in,
    input  side_t   side_in,
    output logic    valid_out,
    output cordic_t d_out,
    output side_t   side_out
);

    localparam logic signed [CW-1:0] ATAN = CW'(atan_entry(I));

    logic    valid_reg;
    cordic_t d_reg;
    cordic_t d_next;
    side_t   side_reg;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    always_comb
    begin
        dx = d_in.y >>> I;
        dy = d_in.x >>> I;
        if (d_in.z >= 0)
        begin
            d_next.x = d_in.x - dx;
            d_next.y = d_in.y + dy;
            d_next.z = d_in.z - ATAN;
        end
        else
        begin
            d_next.x = d_in.x + dx;
            d_next.y = d_in.y - dy;
            d_next.z = d_in.z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg    <= d_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign d_out     = d_reg;
    assign side_out  = side_reg;

endmodule

>>> rtl/core/twem_post.sv
// Six-stage multiply pipeline that builds R and the translation from sin/cos.
// Depends on twem_pkg; the last stage is the response register.
module twem_post
    import twem_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    adv,
    input  logic    valid_in,
    input  cordic_t d_in,
    input  side_t   side_in,
    output logic    valid_out,
    output word_t   rot[9],
    output word_t   trans[3]
);

    localparam wide_t SAT_HI = (72'sd1 <<< (DATA_WIDTH - 1)) - 72'sd1;
    localparam wide_t SAT_LO = -SAT_HI - 72'sd1;
    localparam wide_t DIAG_ONE = 72'sd1 <<< 60;
    localparam logic signed [38:0] Q30_E = 39'sh40000000;

    function automatic wide_t sat_dw(input wide_t x);
        wide_t r;
        if (x > SAT_HI)
            r = SAT_HI;
        else if (x < SAT_LO)
            r = SAT_LO;
        else
            r = x;
        return r;
    endfunction

    // Stage 1: sine, one minus cosine and all products of the axis.
    logic                 v1_reg;
    side_t                s1_reg;
    logic signed [CW-1:0] sn1_reg;
    logic signed [37:0]   omc1_reg;
    logic signed [63:0]   pww1_reg[6];
    logic signed [63:0]   pwv1_reg[9];
    logic signed [CW-1:0] cs;
    logic signed [37:0]   omc_next;
    logic signed [63:0]   pww_next[6];
    logic signed [63:0]   pwv_next[9];
    word_t                wa[3];
    word_t                va[3];

    always_comb
    begin
        wa[0] = side_in.w0;
        wa[1] = side_in.w1;
        wa[2] = side_in.w2;
        va[0] = side_in.v0;
        va[1] = side_in.v1;
        va[2] = side_in.v2;
        cs = side_in.flip ? -d_in.x : d_in.x;
        omc_next = 38'(Q30_ONE) - 38'(cs);
        pww_next[0] = wa[0] * wa[0];
        pww_next[1] = wa[1] * wa[1];
        pww_next[2] = wa[2] * wa[2];
        pww_next[3] = wa[0] * wa[1];
        pww_next[4] = wa[0] * wa[2];
        pww_next[5] = wa[1] * wa[2];
        pwv_next[0] = wa[1] * va[2];
        pwv_next[1] = wa[2] * va[1];
        pwv_next[2] = wa[2] * va[0];
        pwv_next[3] = wa[0] * va[2];
        pwv_next[4] = wa[0] * va[1];
        pwv_next[5] = wa[1] * va[0];
        pwv_next[6] = wa[0] * va[0];
        pwv_next[7] = wa[1] * va[1];
        pwv_next[8] = wa[2] * va[2];
    end

    // Stage 2: W*W entries, w x v and w.v, all rounded to 30 fraction bits less.
    logic                 v2_reg;
    side_t                s2_reg;
    logic signed [CW-1:0] sn2_reg;
    logic signed [37:0]   omc2_reg;
    logic signed [CW-1:0] m2_reg[6];
    logic signed [CW-1:0] u2_reg[3];
    logic signed [CW-1:0] wv2_reg;
    logic signed [CW-1:0] m_next[6];
    logic signed [CW-1:0] u_next[3];
    logic signed [CW-1:0] wv_next;

    always_comb
    begin
        m_next[0] = CW'(rnd30(-wide_t'(pww1_reg[1]) - wide_t'(pww1_reg[2])));
        m_next[1] = CW'(rnd30(-wide_t'(pww1_reg[2]) - wide_t'(pww1_reg[0])));
        m_next[2] = CW'(rnd30(-wide_t'(pww1_reg[0]) - wide_t'(pww1_reg[1])));
        m_next[3] = CW'(rnd30(wide_t'(pww1_reg[3])));
        m_next[4] = CW'(rnd30(wide_t'(pww1_reg[4])));
        m_next[5] = CW'(rnd30(wide_t'(pww1_reg[5])));
        u_next[0] = CW'(rnd30(wide_t'(pwv1_reg[0]) - wide_t'(pwv1_reg[1])));
        u_next[1] = CW'(rnd30(wide_t'(pwv1_reg[2]) - wide_t'(pwv1_reg[3])));
        u_next[2] = CW'(rnd30(wide_t'(pwv1_reg[4]) - wide_t'(pwv1_reg[5])));
        wv_next = CW'(rnd30(wide_t'(pwv1_reg[6]) + wide_t'(pwv1_reg[7])
                            + wide_t'(pwv1_reg[8])));
    end

    // Stage 3: products for R, for k = (w.v)*theta and for the zero-axis case.
    logic                 v3_reg;
    side_t                s3_reg;
    logic signed [CW-1:0] u3_reg[3];
    wide_t                ssn3_reg[3];
    wide_t                mo3_reg[6];
    wide_t                kpl3_reg;
    wide_t                kph3_reg;
    wide_t                pzl3_reg[3];
    wide_t                pzh3_reg[3];
    wide_t                ssn_next[3];
    wide_t                mo_next[6];
    wide_t                kpl_next;
    wide_t                kph_next;
    wide_t                pzl_next[3];
    wide_t                pzh_next[3];
    logic signed [16:0]   thl;
    logic signed [15:0]   thh;
    word_t                wb[3];
    word_t                vb[3];

    always_comb
    begin
        wb[0] = s2_reg.w0;
        wb[1] = s2_reg.w1;
        wb[2] = s2_reg.w2;
        vb[0] = s2_reg.v0;
        vb[1] = s2_reg.v1;
        vb[2] = s2_reg.v2;
        thl = $signed({1'b0, s2_reg.th[15:0]});
        thh = s2_reg.th[31:16];
        for (int n = 0; n < 3; n++)
        begin
            ssn_next[n] = wb[n] * sn2_reg;
            pzl_next[n] = vb[n] * thl;
            pzh_next[n] = vb[n] * thh;
        end
        for (int n = 0; n < 6; n++)
        begin
            mo_next[n] = m2_reg[n] * omc2_reg;
        end
        kpl_next = wv2_reg * thl;
        kph_next = wv2_reg * thh;
    end

    // Stage 4: rotation entries, k and the zero-axis translation.
    logic                 v4_reg;
    side_t                s4_reg;
    logic signed [CW-1:0] u4_reg[3];
    logic signed [37:0]   rot4_reg[9];
    logic signed [51:0]   k4_reg;
    logic signed [47:0]   pz4_reg[3];
    wide_t                racc[9];
    logic signed [37:0]   rot_next[9];
    logic signed [51:0]   k_next;
    logic signed [47:0]   pz_next[3];

    always_comb
    begin
        racc[0] = DIAG_ONE + mo3_reg[0];
        racc[4] = DIAG_ONE + mo3_reg[1];
        racc[8] = DIAG_ONE + mo3_reg[2];
        racc[1] = -ssn3_reg[2] + mo3_reg[3];
        racc[3] = ssn3_reg[2] + mo3_reg[3];
        racc[2] = ssn3_reg[1] + mo3_reg[4];
        racc[6] = -ssn3_reg[1] + mo3_reg[4];
        racc[5] = -ssn3_reg[0] + mo3_reg[5];
        racc[7] = ssn3_reg[0] + mo3_reg[5];
        for (int n = 0; n < 9; n++)
        begin
            rot_next[n] = 38'(sat_dw(rnd30(racc[n])));
        end
        k_next = 52'(kph3_reg + ((kpl3_reg + 72'sd32768) >>> 16));
        for (int n = 0; n < 3; n++)
        begin
            pz_next[n] = 48'(sat_dw(pzh3_reg[n] + ((pzl3_reg[n] + 72'sd32768) >>> 16)));
        end
    end

    // Stage 5: (I - R) times w x v, and w times k split into two partial products.
    logic                 v5_reg;
    logic                 z5_reg;
    logic signed [37:0]   rot5_reg[9];
    logic signed [47:0]   pz5_reg[3];
    wide_t                eu5_reg[9];
    wide_t                wkl5_reg[3];
    wide_t                wkh5_reg[3];
    logic signed [38:0]   e[9];
    wide_t                eu_next[9];
    wide_t                wkl_next[3];
    wide_t                wkh_next[3];
    logic signed [16:0]   kl;
    logic signed [35:0]   kh;
    word_t                wc[3];

    always_comb
    begin
        wc[0] = s4_reg.w0;
        wc[1] = s4_reg.w1;
        wc[2] = s4_reg.w2;
        kl = $signed({1'b0, k4_reg[15:0]});
        kh = k4_reg[51:16];
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                e[i*3+j] = ((i == j) ? Q30_E : 39'sd0) - 39'(rot4_reg[i*3+j]);
                eu_next[i*3+j] = e[i*3+j] * u4_reg[j];
            end
            wkl_next[i] = wc[i] * kl;
            wkh_next[i] = wc[i] * kh;
        end
    end

    // Stage 6: translation sums and the response register.
    logic  v6_reg;
    word_t rot6_reg[9];
    word_t trans6_reg[3];
    word_t rot_out_next[9];
    word_t trans_out_next[3];
    wide_t tacc[3];
    wide_t tsat[3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tacc[i] = (wkh5_reg[i] + ((wkl5_reg[i] + (72'sd1 <<< 29)) >>> 16)) >>> 14;
            for (int j = 0; j < 3; j++)
            begin
                tacc[i] = tacc[i] + rnd30(eu5_reg[i*3+j]);
            end
            tsat[i] = sat_dw(tacc[i]);
            trans_out_next[i] = z5_reg ? pz5_reg[i][31:0] : tsat[i][31:0];
        end
        for (int n = 0; n < 9; n++)
        begin
            if (z5_reg)
                rot_out_next[n] = (n % 4 == 0) ? Q30_ONE : 32'sd0;
            else
                rot_out_next[n] = rot5_reg[n][31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg   <= side_in;
            sn1_reg  <= d_in.y;
            omc1_reg <= omc_next;
            pww1_reg <= pww_next;
            pwv1_reg <= pwv_next;

            s2_reg   <= s1_reg;
            sn2_reg  <= sn1_reg;
            omc2_reg <= omc1_reg;
            m2_reg   <= m_next;
            u2_reg   <= u_next;
            wv2_reg  <= wv_next;

            s3_reg   <= s2_reg;
            u3_reg   <= u2_reg;
            ssn3_reg <= ssn_next;
            mo3_reg  <= mo_next;
            kpl3_reg <= kpl_next;
            kph3_reg <= kph_next;
            pzl3_reg <= pzl_next;
            pzh3_reg <= pzh_next;

            s4_reg   <= s3_reg;
            u4_reg   <= u3_reg;
            rot4_reg <= rot_next;
            k4_reg   <= k_next;
            pz4_reg  <= pz_next;

            z5_reg   <= s4_reg.zero;
            rot5_reg <= rot4_reg;
            pz5_reg  <= pz4_reg;
            eu5_reg  <= eu_next;
            wkl5_reg <= wkl_next;
            wkh5_reg <= wkh_next;

            rot6_reg   <= rot_out_next;
            trans6_reg <= trans_out_next;
        end
    end

    assign valid_out = v6_reg;
    assign rot       = rot6_reg;
    assign trans     = trans6_reg;

endmodule

>>> rtl/core/twist_exponential_map_unit.sv
// Throughput: one request per cycle; every stage advances together, held only
// when the response register is full and not being taken.
// Reset (rst_n, asynchronous, active low) clears all stage valid bits; the
// datapath registers are not reset.
// Depends on twem_pkg, twem_if, twem_mod_cell, twem_cordic_cell and twem_post.
module twist_exponential_map_unit
    import twem_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int DATA_WIDTH   = DATA_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    twem_req_if.sink    req,
    twem_rsp_if.source  rsp
);

    // The datapath is a chain of cells. The first fifteen cells reduce theta
    // modulo 2*pi by conditional subtraction of 2*pi scaled by 2^14 down to
    // 2^0; an offset of 2*pi*2^14 added up front makes the value non-negative
    // without changing the residue. The angle is then folded into
    // [-pi/2, pi/2] and fed to CORDIC_STEPS micro-rotation cells. A six-stage
    // multiply pipeline finally forms R and the translation. The twist itself
    // rides along each cell as sideband data.

    localparam logic signed [51:0] MOD_OFFSET = 52'sh6487ED511 <<< 14;

    // One global advance: the whole chain moves when the response register
    // is empty or its request is being taken this cycle.
    logic adv;
    logic out_valid;

    assign adv       = !out_valid || rsp.ready;
    assign req.ready = adv;

    // Entry: clamp the axis to [-1, 1], move it to Q2.30, detect the zero axis.
    function automatic word_t axis_q30(input word_t a);
        word_t c;
        if (a > AXIS_LIMIT)
            c = AXIS_LIMIT;
        else if (a < -AXIS_LIMIT)
            c = -AXIS_LIMIT;
        else
            c = a;
        return c <<< 14;
    endfunction

    side_t             side_init;
    logic signed [51:0] r_sum;
    logic [MOD_W-1:0]  mod_r[MOD_CELLS+1];
    side_t             mod_side[MOD_CELLS+1];
    logic              mod_valid[MOD_CELLS+1];

    always_comb
    begin
        side_init.v0   = req.lin_x;
        side_init.v1   = req.lin_y;
        side_init.v2   = req.lin_z;
        side_init.w0   = axis_q30(req.ang_x);
        side_init.w1   = axis_q30(req.ang_y);
        side_init.w2   = axis_q30(req.ang_z);
        side_init.th   = req.theta;
        side_init.zero = (req.ang_x == 32'sd0) && (req.ang_y == 32'sd0)
                         && (req.ang_z == 32'sd0);
        side_init.flip = 1'b0;
        r_sum = (52'(req.theta) <<< 16) + MOD_OFFSET;
    end

    assign mod_r[0]     = r_sum[MOD_W-1:0];
    assign mod_side[0]  = side_init;
    assign mod_valid[0] = req.valid;

    for (genvar g = 0; g < MOD_CELLS; g++)
    begin : g_mod
        twem_mod_cell #(
            .K(MOD_CELLS - 1 - g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .valid_in  (mod_valid[g]),
            .r_in      (mod_r[g]),
            .side_in   (mod_side[g]),
            .valid_out (mod_valid[g+1]),
            .r_out     (mod_r[g+1]),
            .side_out  (mod_side[g+1])
        );
    end

    // Fold: map [0, 2*pi) to (-pi, pi], then into [-pi/2, pi/2]. When the
    // angle is mirrored about +-pi/2 the cosine changes sign, which is
    // carried down the chain as the flip flag.
    logic signed [37:0] rs;
    logic signed [37:0] rf;
    side_t              fold_side;
    cordic_t            cd_init;
    cordic_t            cd[CORDIC_STEPS+1];
    side_t              cd_side[CORDIC_STEPS+1];
    logic               cd_valid[CORDIC_STEPS+1];

    always_comb
    begin
        rs = $signed({3'b000, mod_r[MOD_CELLS][34:0]});
        if (rs > PI_Q32)
            rs = rs - TWO_PI_Q32_S;
        fold_side = mod_side[MOD_CELLS];
        if (rs > HALF_PI_Q32)
        begin
            rf = PI_Q32 - rs;
            fold_side.flip = 1'b1;
        end
        else if (rs < -HALF_PI_Q32)
        begin
            rf = -PI_Q32 - rs;
            fold_side.flip = 1'b1;
        end
        else
        begin
            rf = rs;
        end
        cd_init.x = CORDIC_INV_GAIN;
        cd_init.y = '0;
        cd_init.z = CW'(rf >>> 2);
    end

    assign cd[0]       = cd_init;
    assign cd_side[0]  = fold_side;
    assign cd_valid[0] = mod_valid[MOD_CELLS];

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cordic
        twem_cordic_cell #(
            .I(g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .valid_in  (cd_valid[g]),
            .d_in      (cd[g]),
            .side_in   (cd_side[g]),
            .valid_out (cd_valid[g+1]),
            .d_out     (cd[g+1]),
            .side_out  (cd_side[g+1])
        );
    end

    // Rodrigues' formula and the translation; its last stage holds the response.
    word_t rot[9];
    word_t trans[3];

    twem_post #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (cd_valid[CORDIC_STEPS]),
        .d_in      (cd[CORDIC_STEPS]),
        .side_in   (cd_side[CORDIC_STEPS]),
        .valid_out (out_valid),
        .rot       (rot),
        .trans     (trans)
    );

    assign rsp.valid   = out_valid;
    assign rsp.rot_00  = rot[0];
    assign rsp.rot_01  = rot[1];
    assign rsp.rot_02  = rot[2];
    assign rsp.rot_10  = rot[3];
    assign rsp.rot_11  = rot[4];
    assign rsp.rot_12  = rot[5];
    assign rsp.rot_20  = rot[6];
    assign rsp.rot_21  = rot[7];
    assign rsp.rot_22  = rot[8];
    assign rsp.trans_x = trans[0];
    assign rsp.trans_y = trans[1];
    assign rsp.trans_z = trans[2];

endmodule
